### sv/ms_pkg.sv
package ms_pkg;

   // element width and default capacity
   localparam int DATA_W           = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   // one request: a list element and its end mark
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_flag;
   } ms_req_type;

   // one result: a sorted element with its marks
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     dropped;
   } ms_rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // store the request element
      logic sort_init;   // first merge width, source is buffer a
      logic pass_chk;    // start of a pass: first run pair, drain index
      logic group_set;   // set bounds of the current run pair
      logic rd_left;     // read head of the left run
      logic rd_right;    // take left head, read head of the right run
      logic cap_right;   // take right head
      logic merge;       // move the smaller head to the destination
      logic cap_wait;    // refill the head that was just consumed
      logic advance;     // next run pair or next pass
      logic drain;       // read one sorted element for output
   } ms_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sorted;      // run width covers the whole list
      logic group_end;   // the merge writes the last slot of the run pair
      logic list_end;    // the current run pair ends the pass
      logic drain_end;   // the drain reads the last element
   } ms_sts_type;

endpackage

### sv/ms_ram.sv
module ms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### sv/ms_ctrl.sv
module ms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               last_flag,
   input  ms_pkg::ms_sts_type sts,
   output ms_pkg::ms_cmd_type cmd,
   output logic               busy
);

   import ms_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_PASS  = 10'b00_0000_0010,
      ST_GROUP = 10'b00_0000_0100,
      ST_RDL   = 10'b00_0000_1000,
      ST_RDR   = 10'b00_0001_0000,
      ST_CAPR  = 10'b00_0010_0000,
      ST_MERGE = 10'b00_0100_0000,
      ST_WAIT  = 10'b00_1000_0000,
      ST_NEXT  = 10'b01_0000_0000,
      ST_DRAIN = 10'b10_0000_0000
   } ms_state_type;

   ms_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load      = 1'b1;
               cmd.sort_init = last_flag;
               if (last_flag) begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            cmd.pass_chk = 1'b1;
            state_in     = sts.sorted ? ST_DRAIN : ST_GROUP;
         end
         ST_GROUP: begin
            cmd.group_set = 1'b1;
            state_in      = ST_RDL;
         end
         ST_RDL: begin
            cmd.rd_left = 1'b1;
            state_in    = ST_RDR;
         end
         ST_RDR: begin
            cmd.rd_right = 1'b1;
            state_in     = ST_CAPR;
         end
         ST_CAPR: begin
            cmd.cap_right = 1'b1;
            state_in      = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = sts.group_end ? ST_NEXT : ST_WAIT;
         end
         ST_WAIT: begin
            cmd.cap_wait = 1'b1;
            state_in     = ST_MERGE;
         end
         ST_NEXT: begin
            cmd.advance = 1'b1;
            state_in    = sts.list_end ? ST_PASS : ST_GROUP;
         end
         ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (sts.drain_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### sv/ms_dp.sv
module ms_dp #(
   parameter int MAX_ELEMENTS = ms_pkg::MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ms_pkg::ms_cmd_type cmd,
   input  ms_pkg::ms_req_type req,
   output ms_pkg::ms_sts_type sts,
   output ms_pkg::ms_rsp_type rsp,
   output logic               rsp_valid
);

   import ms_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int SW = CW + 2;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW:0]   w_ff, w_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] l_ff, l_in;
   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] j_ff, j_in;
   logic          src_ff, src_in;
   logic          took_l_ff, took_l_in;
   logic signed [DATA_W-1:0] head_l_ff, head_l_in;
   logic signed [DATA_W-1:0] head_r_ff, head_r_in;
   logic          drv_ff, drv_in;
   logic          drl_ff, drl_in;
   logic          drd_ff, drd_in;

   logic [SW-1:0] mid_sum, hi_sum, n_ext, mid_calc, hi_calc;
   logic [CW-1:0] l_inc, r_inc;
   logic          room, take_l;
   logic signed [DATA_W-1:0] pick;

   logic              we_a, we_b, re;
   logic [AW-1:0]     waddr, raddr;
   logic [DATA_W-1:0] wdata, q_a, q_b, q_src;

   // run pair bounds, clipped to the list length
   assign n_ext    = SW'(count_ff);
   assign mid_sum  = SW'(lo_ff) + SW'(w_ff);
   assign hi_sum   = SW'(lo_ff) + {w_ff, 1'b0};
   assign mid_calc = (mid_sum < n_ext) ? mid_sum : n_ext;
   assign hi_calc  = (hi_sum < n_ext) ? hi_sum : n_ext;

   assign room   = (count_ff < CW'(MAX_ELEMENTS));
   assign l_inc  = l_ff + CW'(1);
   assign r_inc  = r_ff + CW'(1);
   assign q_src  = src_ff ? q_b : q_a;

   // left run wins ties, an exhausted run never wins
   assign take_l = (l_ff < mid_ff) && ((r_ff >= hi_ff) || (head_l_ff <= head_r_ff));
   assign pick   = take_l ? head_l_ff : head_r_ff;

   // status
   assign sts.sorted    = ({1'b0, count_ff} <= w_ff);
   assign sts.group_end = ((k_ff + CW'(1)) == hi_ff);
   assign sts.list_end  = (hi_ff == count_ff);
   assign sts.drain_end = ((j_ff + CW'(1)) == count_ff);

   // buffer ports: load and merge writes, source reads
   always_comb begin
      we_a  = 1'b0;
      we_b  = 1'b0;
      waddr = count_ff[AW-1:0];
      wdata = req.value;
      re    = 1'b0;
      raddr = l_ff[AW-1:0];
      if (cmd.load) begin
         we_a = room;
      end else if (cmd.merge) begin
         we_a  = src_ff;
         we_b  = !src_ff;
         waddr = k_ff[AW-1:0];
         wdata = pick;
      end
      if (cmd.rd_left) begin
         re = 1'b1;
      end else if (cmd.rd_right) begin
         re    = 1'b1;
         raddr = r_ff[AW-1:0];
      end else if (cmd.merge) begin
         re    = 1'b1;
         raddr = take_l ? l_inc[AW-1:0] : r_inc[AW-1:0];
      end else if (cmd.drain) begin
         re    = 1'b1;
         raddr = j_ff[AW-1:0];
      end
   end

   // next values of the sort registers
   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      w_in      = w_ff;
      lo_in     = lo_ff;
      mid_in    = mid_ff;
      hi_in     = hi_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      src_in    = src_ff;
      took_l_in = took_l_ff;
      head_l_in = head_l_ff;
      head_r_in = head_r_ff;
      drv_in    = cmd.drain;
      drl_in    = cmd.drain && sts.drain_end;
      drd_in    = ovf_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.sort_init) begin
         w_in   = (CW + 1)'(1);
         src_in = 1'b0;
      end
      if (cmd.pass_chk) begin
         lo_in = '0;
         j_in  = '0;
      end
      if (cmd.group_set) begin
         mid_in = mid_calc[CW-1:0];
         hi_in  = hi_calc[CW-1:0];
         l_in   = lo_ff;
         r_in   = mid_calc[CW-1:0];
         k_in   = lo_ff;
      end
      if (cmd.rd_right) begin
         head_l_in = q_src;
      end
      if (cmd.cap_right) begin
         head_r_in = q_src;
      end
      if (cmd.merge) begin
         k_in      = k_ff + CW'(1);
         took_l_in = take_l;
         if (take_l) begin
            l_in = l_inc;
         end else begin
            r_in = r_inc;
         end
      end
      if (cmd.cap_wait) begin
         if (took_l_ff) begin
            head_l_in = q_src;
         end else begin
            head_r_in = q_src;
         end
      end
      if (cmd.advance) begin
         if (sts.list_end) begin
            w_in   = {w_ff[CW-1:0], 1'b0};
            src_in = !src_ff;
         end else begin
            lo_in = hi_ff;
         end
      end
      if (cmd.drain) begin
         j_in = j_ff + CW'(1);
         if (sts.drain_end) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         drv_ff   <= 1'b0;
         src_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         drv_ff   <= drv_in;
         src_ff   <= src_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      lo_ff     <= lo_in;
      mid_ff    <= mid_in;
      hi_ff     <= hi_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      took_l_ff <= took_l_in;
      head_l_ff <= head_l_in;
      head_r_ff <= head_r_in;
      drl_ff    <= drl_in;
      drd_ff    <= drd_in;
   end

   // ping-pong buffers
   ms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_buf_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (q_a)
   );

   ms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_buf_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (q_b)
   );

   // result strobe comes in the cycle after the drain read
   assign rsp_valid        = drv_ff;
   assign rsp.sorted_value = q_src;
   assign rsp.last_out     = drl_ff;
   assign rsp.dropped      = drd_ff;

endmodule

### sv/merge_sorter_top.sv
// Stable ascending merge sorter. Elements are loaded one per cycle while busy is low
// (start high); the element with last_flag set closes the list. Up to MAX_ELEMENTS
// elements are kept, later ones are discarded and every result of that list has
// dropped set. The list is then sorted by bottom-up merge passes between two
// buffers: ceil(log2(n)) passes, each opened by a width check that after the last
// pass finds the list sorted. Each run pair sets its bounds, reads the left then
// the right head and merges, each merge but the last refilling the consumed head,
// as the source buffer has a single read port. Then n results follow on consecutive
// cycles, each shown for exactly one cycle with rsp_valid high and last_out on the
// final one. The receiver cannot stall: every strobed result must be taken at once.
// busy stays high from the closing element until the cycle that shows the last
// result, in which busy is already low and the next list may start loading.
module merge_sorter_top #(
   parameter int MAX_ELEMENTS = ms_pkg::MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ms_pkg::ms_req_type req_data,
   output logic               rsp_valid,
   output ms_pkg::ms_rsp_type rsp_data
);

   import ms_pkg::*;

   ms_cmd_type cmd;
   ms_sts_type sts;

   // sequencer
   ms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_flag (req_data.last_flag),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // buffers, run pointers and merge compare
   ms_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_data),
      .sts       (sts),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

### tb/sv/merge_sorter_checker.sv
`timescale 1ns / 1ps

module merge_sorter_checker #(
   parameter int MAX_ELEMENTS = ms_pkg::MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  ms_pkg::ms_req_type req,
   input  logic               rsp_valid,
   input  ms_pkg::ms_rsp_type rsp,
   output int                 fail_count,
   output int                 results_owed
);

   import ms_pkg::*;

   typedef logic signed [DATA_W-1:0] key_type;

   // own copy of the list being loaded
   key_type    list_buf [MAX_ELEMENTS];
   key_type    sorted_buf [MAX_ELEMENTS];
   int         held_count;
   logic       drop_seen;
   int         fail_total;
   ms_rsp_type sorted_q [$];

   // bottom-up merge of the held elements, run widths 1, 2, 4, ...
   function automatic void merge_sort_held();
      key_type src [MAX_ELEMENTS];
      key_type dst [MAX_ELEMENTS];
      int   width;
      int   lo;
      int   mid;
      int   hi;
      int   l;
      int   r;
      int   k;
      src = list_buf;
      dst = list_buf;
      for (width = 1; width < held_count; width = width * 2) begin
         for (lo = 0; lo < held_count; lo = lo + 2 * width) begin
            mid = (lo + width < held_count) ? lo + width : held_count;
            hi  = (lo + 2 * width < held_count) ? lo + 2 * width : held_count;
            l   = lo;
            r   = mid;
            k   = lo;
            while (l < mid || r < hi) begin
               // left run wins ties
               if (r >= hi || (l < mid && src[l] <= src[r])) begin
                  dst[k] = src[l];
                  l++;
               end else begin
                  dst[k] = src[r];
                  r++;
               end
               k++;
            end
         end
         src = dst;
      end
      sorted_buf = src;
   endfunction

   // list closed: one expected result per held element
   function automatic void close_list();
      ms_rsp_type entry;
      merge_sort_held();
      for (int k = 0; k < held_count; k++) begin
         entry.sorted_value = sorted_buf[k];
         entry.last_out     = (k == held_count - 1);
         entry.dropped      = drop_seen;
         sorted_q.push_back(entry);
      end
      held_count = 0;
      drop_seen  = 1'b0;
   endfunction

   always @(posedge clock) begin
      ms_rsp_type want;
      if (reset) begin
         held_count = 0;
         drop_seen  = 1'b0;
         sorted_q.delete();
      end else begin
         // accepted request: store or drop, close on the end mark
         if (start && !busy) begin
            if (held_count < MAX_ELEMENTS) begin
               list_buf[held_count] = req.value;
               held_count++;
            end else begin
               drop_seen = 1'b1;
            end
            if (req.last_flag)
               close_list();
         end
         // strobed result against the oldest expectation
         if (rsp_valid) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected result: sorted_value %0d", rsp.sorted_value);
               fail_total++;
            end else begin
               want = sorted_q.pop_front();
               if (rsp.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp.sorted_value);
                  fail_total++;
               end
               if (rsp.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp.last_out);
                  fail_total++;
               end
               if (rsp.dropped !== want.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp.dropped);
                  fail_total++;
               end
            end
         end
      end
      fail_count   <= fail_total;
      results_owed <= sorted_q.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   import ms_pkg::*;

   localparam logic signed [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   ms_req_type req   = '0;
   logic       busy;
   logic       rsp_valid;
   ms_rsp_type rsp;

   int fail_count;
   int results_owed;
   int items_sent;
   bit idle_on;

   always #10 clock = ~clock;

   merge_sorter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp)
   );

   merge_sorter_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req          (req),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // watchdog
   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // mix of extremes, near-zero duplicates and full-range keys
   function automatic logic signed [DATA_W-1:0] pick_key();
      case ($urandom_range(0, 7))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2, 3: return $signed(DATA_W'($urandom_range(0, 8))) - 4;
         default: return $urandom();
      endcase
   endfunction

   // one request, with an optional idle burst in front of it
   task automatic send_element(input logic signed [DATA_W-1:0] key, input logic is_last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req   <= '{value: key, last_flag: is_last};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send_list(input int len);
      for (int i = 0; i < len; i++)
         send_element(pick_key(), i == len - 1);
   endtask

   // stop sending until every sorted element is out
   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   initial begin
      int list_idx;
      int len;
      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // single-element list
      send_element(5, 1'b1);
      // two elements, reversed and already in order
      send_element(KEY_MAX, 1'b0);
      send_element(KEY_MIN, 1'b1);
      send_element(KEY_MIN, 1'b0);
      send_element(KEY_MAX, 1'b1);
      // extremes with duplicates
      send_element(0, 1'b0);
      send_element(-1, 1'b0);
      send_element(1, 1'b0);
      send_element(-1, 1'b0);
      send_element(0, 1'b0);
      send_element(KEY_MIN, 1'b0);
      send_element(KEY_MAX, 1'b0);
      send_element(KEY_MIN, 1'b1);
      // strictly descending
      send_element(100, 1'b0);
      send_element(50, 1'b0);
      send_element(0, 1'b0);
      send_element(-50, 1'b0);
      send_element(-100, 1'b1);
      // all keys equal
      send_element(-7, 1'b0);
      send_element(-7, 1'b0);
      send_element(-7, 1'b1);

      hold_until_drained();

      // random lists, one full list and one that overflows past capacity
      list_idx = 0;
      while (items_sent < 210) begin
         if (list_idx == 2)
            len = ms_pkg::MAX_ELEMENTS_DEF;
         else if (list_idx == 5)
            len = ms_pkg::MAX_ELEMENTS_DEF + $urandom_range(1, 3);
         else
            len = $urandom_range(1, 10);
         idle_on = (items_sent < 170);
         send_list(len);
         list_idx++;
      end

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
